// ===== design/sbpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbpp_pkg;

  // Command codes
  localparam logic [2:0] CMD_WR_DATA = 3'd0;
  localparam logic [2:0] CMD_WR_DIR  = 3'd1;
  localparam logic [2:0] CMD_READ    = 3'd2;
  localparam logic [2:0] CMD_ADVANCE = 3'd3;
  localparam logic [2:0] CMD_STATUS  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_P0_CONN    = 3'd0;
  localparam logic [2:0] REG_P0_SIX     = 3'd1;
  localparam logic [2:0] REG_P1_CONN    = 3'd2;
  localparam logic [2:0] REG_P1_SIX     = 3'd3;
  localparam logic [2:0] REG_TIMEOUT    = 3'd4;
  localparam logic [2:0] REG_RISE_DELAY = 3'd5;

  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned TIMEOUT_W  = 24;
  localparam int unsigned DELAY_W    = 10;
  // Idle counter saturates one past the largest timeout
  localparam int unsigned ELAPSED_W  = TIMEOUT_W + 1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd80000;
  localparam logic [DELAY_W-1:0]   DELAY_RST   = 10'd172;

  localparam logic [7:0] DIGEST_SEED   = 8'h5A;
  localparam logic [7:0] DIGEST_SELECT = 8'h20;
  localparam logic [7:0] DIGEST_PEND   = 8'h33;
  localparam logic [7:0] PULSE_MULT    = 8'd13;
  localparam logic [3:0] PULSE_MAX     = 4'd8;
  localparam logic [3:0] PULSE_SIX     = 4'd4;

  localparam logic [6:0] PAGE_FULL = 7'h7F;
  localparam logic [6:0] PAGE_ID   = 7'h3F;
  localparam logic [6:0] PAGE_LOW  = 7'h33;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        port_select;
    logic [7:0]  write_value;
    logic [31:0] tick_count;
    logic [11:0] buttons;
  } in_item_t;

  typedef struct packed {
    logic [6:0] port_data;
    logic [7:0] capabilities;
    logic [7:0] digest;
  } out_item_t;

  typedef struct packed {
    logic connected;
    logic six_button;
  } port_cfg_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] session_timeout;
    logic [DELAY_W-1:0]   select_rise_delay;
  } timing_cfg_t;

  typedef struct packed {
    logic        wr_data;
    logic        wr_dir;
    logic        rd;
    logic        adv;
    logic        deadline_wraps;
    logic [6:0]  write_value;
    logic [31:0] tick_count;
    logic [11:0] buttons;
  } port_op_t;

  typedef struct packed {
    logic [6:0] port_data;
    logic [7:0] capabilities;
    logic [7:0] digest;
  } port_resp_t;

endpackage

`default_nettype wire

// ===== design/sbpp_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbpp_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sbpp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output sbpp_pkg::port_cfg_t              port0_cfg,
  output sbpp_pkg::port_cfg_t              port1_cfg,
  output sbpp_pkg::timing_cfg_t            timing_cfg
);
  import sbpp_pkg::*;

  logic                 p0_conn_r, p0_six_r, p1_conn_r, p1_six_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [DELAY_W-1:0]   delay_r;
  logic [2:0]           reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_conn_r <= 1'b1;
      p0_six_r  <= 1'b1;
      p1_conn_r <= 1'b0;
      p1_six_r  <= 1'b1;
      timeout_r <= TIMEOUT_RST;
      delay_r   <= DELAY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_P0_CONN:    p0_conn_r <= pwdata[0];
        REG_P0_SIX:     p0_six_r  <= pwdata[0];
        REG_P1_CONN:    p1_conn_r <= pwdata[0];
        REG_P1_SIX:     p1_six_r  <= pwdata[0];
        REG_TIMEOUT:    timeout_r <= pwdata[TIMEOUT_W-1:0];
        REG_RISE_DELAY: delay_r   <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_P0_CONN:    prdata = {31'd0, p0_conn_r};
      REG_P0_SIX:     prdata = {31'd0, p0_six_r};
      REG_P1_CONN:    prdata = {31'd0, p1_conn_r};
      REG_P1_SIX:     prdata = {31'd0, p1_six_r};
      REG_TIMEOUT:    prdata = {8'd0, timeout_r};
      REG_RISE_DELAY: prdata = {22'd0, delay_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign port0_cfg  = '{connected: p0_conn_r, six_button: p0_six_r};
  assign port1_cfg  = '{connected: p1_conn_r, six_button: p1_six_r};
  assign timing_cfg = '{session_timeout: timeout_r, select_rise_delay: delay_r};

endmodule

`default_nettype wire

// ===== design/sbpp_port.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sbpp_port (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  port_id,
  input  wire sbpp_pkg::port_cfg_t   cfg,
  input  wire sbpp_pkg::timing_cfg_t timing,
  input  wire sbpp_pkg::port_op_t    op,
  output sbpp_pkg::port_resp_t       resp
);
  import sbpp_pkg::*;

  localparam logic [3:0] STEP_EXT = 4'd5;
  localparam logic [3:0] STEP_ID  = 4'd4;

  logic [6:0]           dl_r, dl_nxt;
  logic [6:0]           dir_r, dir_nxt;
  logic                 sel_r, sel_nxt;
  logic [3:0]           pc_r, pc_nxt;
  // Ticks left until select-high shows, and ticks since the last select edge
  logic [DELAY_W-1:0]   rem_r, rem_nxt;
  logic [ELAPSED_W-1:0] elap_r, elap_nxt;

  logic                 conn, six;
  logic [ELAPSED_W-1:0] timeout_ext;
  logic [32:0]          elap_sum;
  logic [ELAPSED_W-1:0] elap_adv;
  logic [DELAY_W-1:0]   rem_adv;
  logic [3:0]           pc_chk, pc_inc;
  logic [6:0]           dl_new, dir_new;
  logic                 drive, next_sel;
  logic [3:0]           step;
  logic [6:0]           page, rd_val;
  logic [7:0]           caps, pc13;

  assign conn        = cfg.connected;
  assign six         = cfg.connected && cfg.six_button;
  assign timeout_ext = {1'b0, timing.session_timeout};

  assign elap_sum = {8'd0, elap_r} + {1'b0, op.tick_count};
  assign elap_adv = (elap_sum[32:TIMEOUT_W] != '0) ? ELAPSED_W'(1) << TIMEOUT_W
                                                    : elap_sum[ELAPSED_W-1:0];
  assign rem_adv  = ({22'd0, rem_r} <= op.tick_count) ? '0
                                                      : rem_r - op.tick_count[DELAY_W-1:0];

  assign pc_chk = (pc_r != '0 && elap_r >= timeout_ext) ? 4'd0 : pc_r;
  assign pc_inc = (pc_r <= 4'd6) ? pc_r + 4'd2 : PULSE_MAX;

  assign dl_new   = op.wr_data ? op.write_value : dl_r;
  assign dir_new  = op.wr_dir ? op.write_value : dir_r;
  assign drive    = dir_new[6] || dir_new == '0;
  assign next_sel = dl_new[6];

  always_comb begin
    dl_nxt   = dl_r;
    dir_nxt  = dir_r;
    sel_nxt  = sel_r;
    pc_nxt   = pc_r;
    rem_nxt  = rem_r;
    elap_nxt = elap_r;
    if (op.wr_data || op.wr_dir) begin
      dl_nxt  = dl_new;
      dir_nxt = dir_new;
      if (drive) begin
        rem_nxt = '0;
        if (six && next_sel && !sel_r) begin
          pc_nxt = pc_inc;
        end
        if (next_sel != sel_r) begin
          elap_nxt = '0;
        end
        sel_nxt = next_sel;
      end else begin
        sel_nxt = 1'b1;
        // Line released while low: select-high shows only after the rise delay, unless the deadline wraps
        if (!sel_r) begin
          rem_nxt = op.deadline_wraps ? '0 : timing.select_rise_delay;
        end
      end
      if (!conn) begin
        pc_nxt  = '0;
        rem_nxt = '0;
      end
    end else if (op.rd) begin
      pc_nxt = pc_chk;
      if (!conn) begin
        pc_nxt  = '0;
        rem_nxt = '0;
      end
    end else if (op.adv) begin
      elap_nxt = elap_adv;
      rem_nxt  = rem_adv;
      if (pc_r != '0 && elap_adv >= timeout_ext) begin
        pc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_r   <= '0;
      dir_r  <= '0;
      sel_r  <= 1'b1;
      pc_r   <= '0;
      rem_r  <= '0;
      elap_r <= '0;
    end else begin
      dl_r   <= dl_nxt;
      dir_r  <= dir_nxt;
      sel_r  <= sel_nxt;
      pc_r   <= pc_nxt;
      rem_r  <= rem_nxt;
      elap_r <= elap_nxt;
    end
  end

  // Pick the button page from select level and pulse count
  always_comb begin
    step = {3'd0, sel_r};
    if (six && pc_chk >= PULSE_SIX) begin
      step = {3'd0, sel_r} | pc_chk;
      if (rem_r != '0) begin
        step[0] = 1'b0;
      end
    end
    case (step)
      STEP_EXT: page = PAGE_FULL & ~{1'b0, op.buttons[6], op.buttons[5], op.buttons[11],
                                     op.buttons[8], op.buttons[9], op.buttons[10]};
      STEP_ID:  page = PAGE_ID & ~{1'b0, op.buttons[7], op.buttons[4], 4'd0};
      default: begin
        if (step[0]) begin
          page = PAGE_FULL & ~{1'b0, op.buttons[6], op.buttons[5], op.buttons[3],
                               op.buttons[2], op.buttons[1], op.buttons[0]};
        end else begin
          page = PAGE_LOW & ~{1'b0, op.buttons[7], op.buttons[4], 2'd0,
                              op.buttons[1], op.buttons[0]};
        end
      end
    endcase
  end

  assign rd_val = conn ? ((page & ~dir_r) | (dl_r & dir_r)) : PAGE_FULL;

  assign caps = {dir_r[5], dir_r[6], port_id, !port_id, dl_r[6], sel_r,
                 pc_r >= PULSE_SIX, conn};
  assign pc13 = {4'd0, pc_r} * PULSE_MULT;

  assign resp.port_data    = rd_val;
  assign resp.capabilities = caps;
  assign resp.digest       = DIGEST_SEED ^ caps ^ {1'b0, dl_r} ^ {dir_r, 1'b0}
                           ^ (sel_r ? DIGEST_SELECT : 8'd0) ^ pc13
                           ^ ((rem_r != '0) ? DIGEST_PEND : 8'd0);

endmodule

`default_nettype wire

// ===== design/six_button_pad_port.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted transaction enters the input register, its result then the result register
// on out_data; commands without a result retire from the input register. Throughput: one
// transaction per cycle unless out_stall holds a result back, set by the single update pass on the port registers.
// Reset (rst_n low, synchronous): pipeline empty, clock and port state cleared, select high,
// configuration registers back to their defaults.

module six_button_pad_port (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire sbpp_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output sbpp_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sbpp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import sbpp_pkg::*;

  in_item_t    s1_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic [63:0] mclk_r, mclk_nxt;

  port_cfg_t   p0_cfg, p1_cfg;
  timing_cfg_t timing;
  port_op_t    op0, op1;
  port_resp_t  resp0, resp1, resp_sel;

  logic        is_wr_data, is_wr_dir, is_read, is_adv, is_stat;
  logic        produces, s1_go, accept;
  logic [64:0] deadline_sum;

  sbpp_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .port0_cfg  (p0_cfg),
    .port1_cfg  (p1_cfg),
    .timing_cfg (timing)
  );

  always_comb begin
    is_wr_data = 1'b0;
    is_wr_dir  = 1'b0;
    is_read    = 1'b0;
    is_adv     = 1'b0;
    is_stat    = 1'b0;
    unique case (s1_r.cmd)
      CMD_WR_DATA: is_wr_data = 1'b1;
      CMD_WR_DIR:  is_wr_dir  = 1'b1;
      CMD_READ:    is_read    = 1'b1;
      CMD_ADVANCE: is_adv     = 1'b1;
      CMD_STATUS:  is_stat    = 1'b1;
      default: ;
    endcase
  end

  assign produces = is_read || is_stat;
  assign s1_go    = s1_valid_r && (!produces || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  // Carry out means the select-high deadline wraps past the clock's range
  assign deadline_sum = {1'b0, mclk_r} + {55'd0, timing.select_rise_delay};

  always_comb begin
    op0.wr_data        = s1_go && is_wr_data && !s1_r.port_select;
    op0.wr_dir         = s1_go && is_wr_dir && !s1_r.port_select;
    op0.rd             = s1_go && is_read && !s1_r.port_select;
    op0.adv            = s1_go && is_adv;
    op0.deadline_wraps = deadline_sum[64];
    op0.write_value    = s1_r.write_value[6:0];
    op0.tick_count     = s1_r.tick_count;
    op0.buttons        = s1_r.buttons;
    op1                = op0;
    op1.wr_data        = s1_go && is_wr_data && s1_r.port_select;
    op1.wr_dir         = s1_go && is_wr_dir && s1_r.port_select;
    op1.rd             = s1_go && is_read && s1_r.port_select;
  end

  sbpp_port u_port0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .port_id (1'b0),
    .cfg     (p0_cfg),
    .timing  (timing),
    .op      (op0),
    .resp    (resp0)
  );

  sbpp_port u_port1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .port_id (1'b1),
    .cfg     (p1_cfg),
    .timing  (timing),
    .op      (op1),
    .resp    (resp1)
  );

  assign resp_sel = s1_r.port_select ? resp1 : resp0;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mclk_nxt      = mclk_r;
    if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_go && produces) begin
      out_valid_nxt = 1'b1;
      if (is_read) begin
        out_nxt = '{port_data: resp_sel.port_data, capabilities: 8'd0, digest: 8'd0};
      end else begin
        out_nxt = '{port_data: 7'd0, capabilities: resp_sel.capabilities,
                    digest: resp_sel.digest};
      end
    end
    if (s1_go && is_adv) begin
      mclk_nxt = mclk_r + {32'd0, s1_r.tick_count};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mclk_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      mclk_r      <= mclk_nxt;
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== test/six_button_pad_port_tb.sv =====
`timescale 1ns / 1ps

module six_button_pad_port_tb;
  import sbpp_pkg::*;

  localparam int unsigned RUN_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned PHASE_ITEMS = 150;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  six_button_pad_port i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pad state mirror
  logic        port_on [2];
  logic        port_six [2];
  logic [23:0] idle_limit;
  logic [9:0]  rise_delay;
  logic [63:0] ticks_now;
  logic [6:0]  dlat [2];
  logic [6:0]  dirm [2];
  logic        sel_lvl [2];
  logic [3:0]  pulses [2];
  logic [63:0] vis_at [2];
  logic [63:0] sel_change_at [2];

  in_item_t  pad_cmds [$];
  out_item_t pad_replies [$];
  out_item_t want_reply;
  int unsigned live_added;
  int unsigned mismatches = 0;
  int unsigned cyc_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  logic quiet;

  // No idling on either side for one stretch in eight
  assign quiet = (cyc_cnt[9:7] == 3'd0);

  function automatic void reset_pads();
    port_on[0] = 1'b1;
    port_six[0] = 1'b1;
    port_on[1] = 1'b0;
    port_six[1] = 1'b1;
    idle_limit = 24'd80000;
    rise_delay = 10'd172;
    ticks_now = 64'd0;
    for (int i = 0; i < 2; i++) begin
      dlat[i] = 7'd0;
      dirm[i] = 7'd0;
      sel_lvl[i] = 1'b1;
      pulses[i] = 4'd0;
      vis_at[i] = 64'd0;
      sel_change_at[i] = 64'd0;
    end
  endfunction

  function automatic void age_out(input bit p);
    if (pulses[p] != 4'd0 && (ticks_now - sel_change_at[p]) >= {40'd0, idle_limit})
      pulses[p] = 4'd0;
  endfunction

  function automatic void drive_select(input bit p);
    logic prev;
    logic nxt;
    prev = sel_lvl[p];
    if (dirm[p][6] || dirm[p] == 7'd0) begin
      nxt = dlat[p][6];
      vis_at[p] = 64'd0;
      if (port_on[p] && port_six[p] && nxt && !prev) begin
        pulses[p] = (pulses[p] <= 4'd6) ? pulses[p] + 4'd2 : 4'd8;
        sel_change_at[p] = ticks_now;
      end
      if (nxt != prev) sel_change_at[p] = ticks_now;
      sel_lvl[p] = nxt;
    end else begin
      // line turned to input: it reads high, but only after the rise delay
      sel_lvl[p] = 1'b1;
      if (!prev) vis_at[p] = ticks_now + {54'd0, rise_delay};
    end
    if (!port_on[p]) begin
      pulses[p] = 4'd0;
      vis_at[p] = 64'd0;
    end
  endfunction

  function automatic logic [6:0] read_pad(input bit p, input logic [11:0] btn);
    logic [3:0] step;
    logic [6:0] v;
    age_out(p);
    if (!port_on[p]) begin
      pulses[p] = 4'd0;
      vis_at[p] = 64'd0;
      return 7'h7F;
    end
    step = {3'b000, sel_lvl[p]};
    if (port_six[p] && pulses[p] >= 4'd4) begin
      step = step | pulses[p];
      if (ticks_now < vis_at[p]) step[0] = 1'b0;
    end
    if (step == 4'd5) begin
      // extra buttons page
      v = 7'h7F;
      if (btn[6]) v[5] = 1'b0;
      if (btn[5]) v[4] = 1'b0;
      if (btn[11]) v[3] = 1'b0;
      if (btn[8]) v[2] = 1'b0;
      if (btn[9]) v[1] = 1'b0;
      if (btn[10]) v[0] = 1'b0;
    end else if (step == 4'd4) begin
      v = 7'h3F;
      if (btn[7]) v[5] = 1'b0;
      if (btn[4]) v[4] = 1'b0;
    end else if (step[0]) begin
      v = 7'h7F;
      if (btn[6]) v[5] = 1'b0;
      if (btn[5]) v[4] = 1'b0;
      if (btn[3]) v[3] = 1'b0;
      if (btn[2]) v[2] = 1'b0;
      if (btn[1]) v[1] = 1'b0;
      if (btn[0]) v[0] = 1'b0;
    end else begin
      v = 7'h33;
      if (btn[7]) v[5] = 1'b0;
      if (btn[4]) v[4] = 1'b0;
      if (btn[1]) v[1] = 1'b0;
      if (btn[0]) v[0] = 1'b0;
    end
    return (v & ~dirm[p]) | (dlat[p] & dirm[p]);
  endfunction

  function automatic void step_pad(input in_item_t it);
    out_item_t r;
    bit p;
    logic [7:0] caps;
    logic [7:0] pm;
    p = it.port_select;
    r = '0;
    case (it.cmd)
      CMD_WR_DATA: begin
        dlat[p] = it.write_value[6:0];
        drive_select(p);
      end
      CMD_WR_DIR: begin
        dirm[p] = it.write_value[6:0];
        drive_select(p);
      end
      CMD_READ: begin
        r.port_data = read_pad(p, it.buttons);
        pad_replies.push_back(r);
      end
      CMD_ADVANCE: begin
        ticks_now = ticks_now + {32'd0, it.tick_count};
        age_out(1'b0);
        age_out(1'b1);
      end
      CMD_STATUS: begin
        caps = p ? 8'h20 : 8'h10;
        if (port_on[p]) caps[0] = 1'b1;
        if (pulses[p] >= 4'd4) caps[1] = 1'b1;
        if (sel_lvl[p]) caps[2] = 1'b1;
        if (dlat[p][6]) caps[3] = 1'b1;
        if (dirm[p][6]) caps[6] = 1'b1;
        if (dirm[p][5]) caps[7] = 1'b1;
        pm = {4'd0, pulses[p]} * 8'd13;
        r.capabilities = caps;
        r.digest = 8'h5A ^ caps ^ {1'b0, dlat[p]} ^ {dirm[p], 1'b0}
                   ^ (sel_lvl[p] ? 8'h20 : 8'h00) ^ pm
                   ^ ((vis_at[p] > ticks_now) ? 8'h33 : 8'h00);
        pad_replies.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic void put(input logic [2:0] cmd, input bit p, input logic [7:0] wv,
                              input logic [31:0] tk, input logic [11:0] btn);
    in_item_t it;
    it.cmd = cmd;
    it.port_select = p;
    it.write_value = wv;
    it.tick_count = tk;
    it.buttons = btn;
    pad_cmds.push_back(it);
    if (cmd <= CMD_STATUS) live_added++;
  endfunction

  function automatic logic [31:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 250);
    if (r < 75) return $urandom_range(0, 1200);
    if (r < 92) return $urandom_range(0, {8'd0, idle_limit} * 2 + 2);
    return $urandom;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // One select-line session on a port: set directions, toggle select, read along the way
  function automatic void add_session();
    logic [31:0] rw;
    logic [31:0] rb;
    bit p;
    bit lvl;
    int unsigned n;
    logic [7:0] dv;
    rw = $urandom;
    p = rw[0];
    lvl = rw[1];
    case (rw[3:2])
      2'b00: dv = {rw[4], 7'h00};
      2'b01: dv = {rw[4], 1'b1, rw[10:5]};
      default: dv = {rw[4], 7'h40};
    endcase
    put(CMD_WR_DIR, p, dv, $urandom, rw[31:20]);
    n = $urandom_range(2, 10);
    for (int k = 0; k < n; k++) begin
      rw = $urandom;
      rb = $urandom;
      lvl = ~lvl;
      put(CMD_WR_DATA, p, {rw[7], lvl, rw[5:0]}, rb, rw[19:8]);
      if (rw[20]) put(CMD_ADVANCE, p, rw[7:0], pick_ticks(), rb[11:0]);
      if (rw[22:21] != 2'b00) put(CMD_READ, p, rw[7:0], rb, rb[31:20]);
      if (rw[24:23] == 2'b00) put(CMD_STATUS, p, rw[7:0], rb, rb[23:12]);
    end
    rw = $urandom;
    rb = $urandom;
    if (rw[1:0] == 2'b00) begin
      // drop select, then switch it to input so the rise stays hidden for a while
      put(CMD_WR_DATA, p, {rw[2], 1'b0, rw[8:3]}, rb, rb[11:0]);
      put(CMD_WR_DIR, p, {rw[9], 1'b0, (rw[15:10] == 6'd0) ? 6'h20 : rw[15:10]},
          rb, rb[23:12]);
      put(CMD_READ, p, rw[23:16], rb, rb[31:20]);
      put(CMD_STATUS, p, rw[23:16], rb, rb[19:8]);
      put(CMD_ADVANCE, p, rw[31:24], $urandom_range(0, {22'd0, rise_delay} + 40), rb[11:0]);
      put(CMD_READ, p, rw[31:24], rb, rb[27:16]);
    end
  endfunction

  function automatic void add_noise();
    logic [31:0] r0;
    logic [31:0] r1;
    r0 = $urandom;
    r1 = $urandom;
    put(r0[2:0], r0[3], r0[11:4], r1, r0[23:12]);
  endfunction

  function automatic void run_random(input int unsigned n);
    live_added = 0;
    while (live_added < n) begin
      if ($urandom_range(0, 99) < 85) add_session();
      else add_noise();
    end
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_P0_CONN: port_on[0] = val[0];
      REG_P0_SIX: port_six[0] = val[0];
      REG_P1_CONN: port_on[1] = val[0];
      REG_P1_SIX: port_six[1] = val[0];
      REG_TIMEOUT: idle_limit = val[23:0];
      REG_RISE_DELAY: rise_delay = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_pads(input bit c0, input bit s0, input bit c1, input bit s1,
                          input logic [23:0] tmo, input logic [9:0] dly);
    cfg_write(REG_P0_CONN, {31'd0, c0});
    cfg_write(REG_P0_SIX, {31'd0, s0});
    cfg_write(REG_P1_CONN, {31'd0, c1});
    cfg_write(REG_P1_SIX, {31'd0, s1});
    cfg_write(REG_TIMEOUT, {8'd0, tmo});
    cfg_write(REG_RISE_DELAY, {22'd0, dly});
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pad_cmds.size() != 0 || in_valid || pad_replies.size() != 0);
    // commands without a reply may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) step_pad(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pad_cmds.size() != 0) begin
          in_data <= pad_cmds.pop_front();
          in_valid <= 1'b1;
          send_gap <= (quiet || $urandom_range(0, 99) >= 30) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      // long hold-off: let the block fill and push back on its input
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left <= idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pad_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transaction port_data=%h capabilities=%h digest=%h",
                   $realtime, out_data.port_data, out_data.capabilities, out_data.digest);
      end else begin
        want_reply = pad_replies.pop_front();
        if (out_data.port_data !== want_reply.port_data ||
            out_data.capabilities !== want_reply.capabilities ||
            out_data.digest !== want_reply.digest) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch port_data exp %h got %h, capabilities exp %h got %h, digest exp %h got %h",
                     $realtime, want_reply.port_data, out_data.port_data,
                     want_reply.capabilities, out_data.capabilities,
                     want_reply.digest, out_data.digest);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] rw;
    reset_pads();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, port 0 six-button, port 1 absent
    put(CMD_STATUS, 1'b0, 8'h00, 32'h0, 12'h000);
    put(CMD_STATUS, 1'b1, 8'hFF, 32'hFFFFFFFF, 12'hFFF);
    put(CMD_READ, 1'b0, 8'h00, 32'h0, 12'h000);
    put(CMD_READ, 1'b0, 8'h00, 32'h0, 12'hFFF);
    put(CMD_READ, 1'b1, 8'h00, 32'h0, 12'hFFF);
    put(CMD_WR_DIR, 1'b0, 8'hC0, 32'h0, 12'h000);
    put(CMD_READ, 1'b0, 8'h00, 32'h0, 12'hFFF);
    put(CMD_WR_DATA, 1'b0, 8'h40, 32'h0, 12'h000);
    put(CMD_WR_DATA, 1'b0, 8'h00, 32'h0, 12'h000);
    put(CMD_WR_DATA, 1'b0, 8'hFF, 32'h0, 12'h000);
    put(CMD_READ, 1'b0, 8'h00, 32'h0, 12'hFFF);
    put(CMD_WR_DATA, 1'b0, 8'h80, 32'h0, 12'h000);
    put(CMD_READ, 1'b0, 8'h00, 32'h0, 12'h0A5);
    put(CMD_STATUS, 1'b0, 8'h00, 32'h0, 12'h000);
    // keep toggling until the count saturates
    for (int k = 0; k < 3; k++) begin
      put(CMD_WR_DATA, 1'b0, 8'h7F, 32'h0, 12'h000);
      put(CMD_WR_DATA, 1'b0, 8'h00, 32'h0, 12'h000);
    end
    put(CMD_WR_DIR, 1'b0, 8'h01, 32'h0, 12'h000);
    put(CMD_STATUS, 1'b0, 8'h00, 32'h0, 12'h000);
    put(CMD_READ, 1'b0, 8'h00, 32'h0, 12'hFFF);
    put(CMD_ADVANCE, 1'b0, 8'h00, 32'hFFFFFFFF, 12'h000);
    put(CMD_READ, 1'b0, 8'h00, 32'h0, 12'h000);
    for (int k = 5; k < 8; k++) begin
      rw = $urandom;
      put(k[2:0], rw[0], rw[8:1], $urandom, rw[20:9]);
    end
    put(CMD_WR_DATA, 1'b1, 8'hFF, 32'h0, 12'h000);
    put(CMD_WR_DIR, 1'b1, 8'h7F, 32'h0, 12'h000);
    put(CMD_STATUS, 1'b1, 8'h00, 32'h0, 12'h000);
    wait_drained();

    @(negedge clk);
    run_random(PHASE_ITEMS);
    wait_drained();

    set_pads(1'b1, 1'b1, 1'b1, 1'b1, 24'hFFFFFF, 10'd0);
    run_random(PHASE_ITEMS);
    hold_go = 1'b1;
    wait_drained();

    set_pads(1'b1, 1'b0, 1'b1, 1'b1, 24'd1, 10'd1023);
    run_random(PHASE_ITEMS);
    wait_drained();

    // zero timeout clears any count at the next check
    set_pads(1'b0, 1'b1, 1'b1, 1'b0, 24'd0, 10'd5);
    run_random(PHASE_ITEMS);
    wait_drained();

    set_pads(1'b1, 1'b1, 1'b1, 1'b1, 24'd300, 10'd100);
    run_random(PHASE_ITEMS);
    wait_drained();

    rw = $urandom;
    set_pads(rw[0], rw[1], rw[2], rw[3], {11'd0, rw[16:4]} + 24'd1, rw[26:17]);
    run_random(PHASE_ITEMS);
    wait_drained();

    if (mismatches == 0 && pad_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
